/* sv/fmnco_pkg.sv */
// ============================================================================
// fmnco_pkg: shared types and constants of the FM modulator NCO
// Widths, register codes, queue sizing and the quarter-wave sine ROM image.
// ============================================================================
package fmnco_pkg;

    localparam int LutBits  = 12;
    localparam int SampleW  = 32;
    localparam int PhaseW   = 32;
    localparam int MagW     = 31;
    localparam int ProdW    = 2 * SampleW + 1;
    localparam int ModLsb   = SampleW - 1;

    localparam int Quarter  = 1 << (LutBits - 2);
    localparam int QAddrW   = LutBits - 1;
    localparam int BankBits = (LutBits - 3 < 7) ? LutBits - 3 : 7;
    localparam int BankSize = 1 << BankBits;
    localparam int NumBanks = (Quarter >> BankBits) + 1;
    localparam int BankSelW = QAddrW - BankBits;
    localparam int RomDepth = NumBanks * BankSize;
    localparam int RomAddrW = $clog2(RomDepth);

    localparam int QDepth   = 4;
    localparam int QPtrW    = $clog2(QDepth);
    localparam int QCntW    = QPtrW + 1;

    localparam int ApbAddrW = 3;
    localparam logic RegCarrier = 1'b0;
    localparam logic RegGain    = 1'b1;

    localparam logic [31:0] CarrierReset = 32'd486957743;
    localparam logic [31:0] GainReset    = 32'd97391;

    localparam logic [63:0] HalfPiQ60 = 64'h1921FB54442D1847;
    localparam logic [63:0] FullScale = 64'd2147483647;

    typedef logic signed [SampleW-1:0] t_sample;
    typedef logic [PhaseW-1:0]         t_phase;
    typedef logic [LutBits-1:0]        t_lut_idx;
    typedef logic [MagW-1:0]           t_mag;
    typedef logic [QAddrW-1:0]         t_qaddr;
    typedef t_mag                      t_rom [RomDepth];

    typedef struct packed {
        logic [31:0] carrier;
        logic [31:0] gain;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // (a*b) >> 60 in unsigned Q60
    function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // sin(pi/2 * j / Quarter) * (2^31 - 1), rounded, Taylor series in Q60
    function automatic t_mag quarter_sine(input logic [31:0] j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] sh;
        logic [63:0] sl;
        logic [63:0] hi;
        logic [63:0] t;
        logic [63:0] r;
        x    = q60_mul(HalfPiQ60, 64'(j) << (62 - LutBits));
        x2   = q60_mul(x, x);
        term = x;
        sum  = x;
        term = q60_mul(term, x2) / 64'd6;   sum = sum - term;
        term = q60_mul(term, x2) / 64'd20;  sum = sum + term;
        term = q60_mul(term, x2) / 64'd42;  sum = sum - term;
        term = q60_mul(term, x2) / 64'd72;  sum = sum + term;
        term = q60_mul(term, x2) / 64'd110; sum = sum - term;
        term = q60_mul(term, x2) / 64'd156; sum = sum + term;
        term = q60_mul(term, x2) / 64'd210; sum = sum - term;
        term = q60_mul(term, x2) / 64'd272; sum = sum + term;
        term = q60_mul(term, x2) / 64'd342; sum = sum - term;
        term = q60_mul(term, x2) / 64'd420; sum = sum + term;
        term = q60_mul(term, x2) / 64'd506; sum = sum - term;
        term = q60_mul(term, x2) / 64'd600; sum = sum + term;
        sh = sum >> 32;
        sl = {32'd0, sum[31:0]};
        hi = sh * FullScale;
        t  = sl * FullScale + (64'd1 << 59);
        r  = (hi + (t >> 32)) >> 28;
        if (r > FullScale) begin
            r = FullScale;
        end
        return r[MagW-1:0];
    endfunction

    // quarter-wave image, banked and zero padded above Quarter
    function automatic t_rom build_rom();
        t_rom rom;
        for (int j = 0; j < RomDepth; j++) begin
            rom[j] = (j <= Quarter) ? quarter_sine(32'(j)) : '0;
        end
        return rom;
    endfunction

    localparam t_rom SineRom = build_rom();

endpackage

/* sv/fmnco_pcm_if.sv */
// ============================================================================
// fmnco_pcm_if: PCM sample stream
// Valid/ready channel carrying one signed audio sample per transaction.
// ============================================================================
interface fmnco_pcm_if;
    import fmnco_pkg::*;

    logic    valid;
    logic    ready;
    t_sample pcm_sample;

    modport source (output valid, output pcm_sample, input ready);
    modport sink   (input valid, input pcm_sample, output ready);
endinterface

/* sv/fmnco_fm_if.sv */
// ============================================================================
// fmnco_fm_if: FM sample stream
// Valid/ready channel carrying one signed modulated sample per transaction.
// ============================================================================
interface fmnco_fm_if;
    import fmnco_pkg::*;

    logic    valid;
    logic    ready;
    t_sample fm_sample;

    modport source (output valid, output fm_sample, input ready);
    modport sink   (input valid, input fm_sample, output ready);
endinterface

/* sv/fmnco_ram.sv */
// ============================================================================
// fmnco_ram: generic single-port-write, single-port-read RAM
// Synchronous write, registered read with read enable (data holds otherwise).
// ============================================================================
module fmnco_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(Depth)-1:0] i_wr_addr,
    input  logic [Width-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(Depth)-1:0] i_rd_addr,
    output logic [Width-1:0]         o_rd_data
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

/* sv/fmnco_front.sv */
// ============================================================================
// fmnco_front: sample intake and phase accumulation
// Scales the sample by the deviation gain, then advances the phase and
// pushes the table index into the queue.
// ============================================================================
module fmnco_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fmnco_pkg::t_cfg      i_cfg,
    input  logic                 i_enable,
    input  fmnco_pkg::t_q_status i_q_status,
    fmnco_pcm_if.sink            i_pcm,
    output logic                 o_push,
    output fmnco_pkg::t_lut_idx  o_push_idx
);
    import fmnco_pkg::*;

    logic                    r_a_vld;
    t_phase                  r_a_mod;
    t_phase                  r_phase;
    t_phase                  n_phase;
    logic signed [ProdW-1:0] w_prod;
    logic                    w_take;

    assign w_prod      = i_pcm.pcm_sample * $signed({1'b0, i_cfg.gain});
    assign o_push      = r_a_vld && !i_q_status.full;
    assign i_pcm.ready = i_enable && (!r_a_vld || !i_q_status.full);
    assign w_take      = i_pcm.valid && i_pcm.ready;
    assign n_phase     = r_phase + i_cfg.carrier + r_a_mod;
    assign o_push_idx  = n_phase[PhaseW-1 -: LutBits];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_phase <= '0;
        end else begin
            if (w_take) begin
                r_a_vld <= 1'b1;
            end else if (o_push) begin
                r_a_vld <= 1'b0;
            end
            if (o_push) begin
                r_phase <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_a_mod <= w_prod[ModLsb +: PhaseW];
        end
    end
endmodule

/* sv/fmnco_queue.sv */
// ============================================================================
// fmnco_queue: short FIFO of table indices
// Decouples phase accumulation from the table lookup and output side.
// ============================================================================
module fmnco_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  fmnco_pkg::t_lut_idx  i_push_idx,
    input  logic                 i_pop,
    output fmnco_pkg::t_lut_idx  o_pop_idx,
    output fmnco_pkg::t_q_status o_status
);
    import fmnco_pkg::*;

    t_lut_idx         r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QCntW-1:0] r_count;

    assign o_status.full  = (r_count == QCntW'(QDepth));
    assign o_status.empty = (r_count == '0);
    assign o_pop_idx      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_idx;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("queue pop while empty");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_status.full || o_status.empty) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
endmodule

/* sv/fmnco_back.sv */
// ============================================================================
// fmnco_back: sine lookup and output stage
// Loads the quarter-wave RAM after reset, then maps each index onto the
// quarter wave, reads the RAM and applies the sign into the output register.
// ============================================================================
module fmnco_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fmnco_pkg::t_q_status i_q_status,
    input  fmnco_pkg::t_lut_idx  i_pop_idx,
    output logic                 o_pop,
    output logic                 o_ready,
    fmnco_fm_if.source           o_fm
);
    import fmnco_pkg::*;

    logic                r_filling;
    t_qaddr              r_fill_cnt;
    logic                r_wr_vld;
    t_qaddr              r_wr_addr;
    logic                r_fill_done;
    t_mag                r_bank [NumBanks];

    logic                r_b_vld;
    logic                r_b_neg;
    logic                r_o_vld;
    t_sample             r_o_data;

    t_qaddr              w_rd_addr;
    t_qaddr              w_frac;
    t_mag                w_mag;
    logic [SampleW-1:0]  w_ext;
    logic                w_out_free;
    logic                w_b_adv;

    // ROM image copy, one entry per cycle through a two-level bank select
    for (genvar b = 0; b < NumBanks; b++) begin : g_bank
        always_ff @(posedge i_clk) begin
            r_bank[b] <= SineRom[RomAddrW'(b * BankSize)
                                 + RomAddrW'(r_fill_cnt[BankBits-1:0])];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filling   <= 1'b1;
            r_fill_cnt  <= '0;
            r_wr_vld    <= 1'b0;
            r_fill_done <= 1'b0;
        end else begin
            r_wr_vld <= r_filling;
            if (r_filling) begin
                if (r_fill_cnt == t_qaddr'(Quarter)) begin
                    r_filling <= 1'b0;
                end else begin
                    r_fill_cnt <= r_fill_cnt + 1'b1;
                end
            end
            if (r_wr_vld && !r_filling) begin
                r_fill_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= r_fill_cnt;
    end

    // quadrant fold: odd quadrants run the quarter wave backwards
    assign w_frac     = t_qaddr'(i_pop_idx[LutBits-3:0]);
    assign w_rd_addr  = i_pop_idx[LutBits-2] ? t_qaddr'(Quarter) - w_frac : w_frac;

    assign w_out_free = !r_o_vld || o_fm.ready;
    assign w_b_adv    = r_b_vld && w_out_free;
    assign o_pop      = r_fill_done && !i_q_status.empty && (!r_b_vld || w_b_adv);
    assign o_ready    = r_fill_done;

    fmnco_ram #(
        .Width (MagW),
        .Depth (Quarter + 1)
    ) u_sine_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_wr_vld),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (r_bank[r_wr_addr[QAddrW-1:BankBits]]),
        .i_rd_en   (o_pop),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_mag)
    );

    assign w_ext = {1'b0, w_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b_vld <= 1'b1;
            end else if (w_b_adv) begin
                r_b_vld <= 1'b0;
            end
            if (w_b_adv) begin
                r_o_vld <= 1'b1;
            end else if (o_fm.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_neg <= i_pop_idx[LutBits-1];
        end
        if (w_b_adv) begin
            r_o_data <= r_b_neg ? $signed(SampleW'(0) - w_ext) : $signed(w_ext);
        end
    end

    assign o_fm.valid     = r_o_vld;
    assign o_fm.fm_sample = r_o_data;

    a_no_load_after_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_vld |-> !r_fill_done)
        else $error("sine RAM written after load finished");

    a_no_read_during_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_fill_done && !r_filling && !r_wr_vld))
        else $error("sine RAM read during load");
endmodule

/* sv/fm_modulator_nco.sv */
// ============================================================================
// fm_modulator_nco: NCO-based FM modulator
// Path: input register, index queue, sine RAM read and output register.
// Throughput: one transaction per cycle unless output back-pressure fills
// the index queue. Reset: phase clears to zero and registers take their
// defaults; input ready stays low after reset while the 1025-entry
// quarter-wave sine RAM loads. Configuration writes are taken throughout.
// ============================================================================
module fm_modulator_nco (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fmnco_pcm_if.sink                         i_pcm,
    fmnco_fm_if.source                        o_fm,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fmnco_pkg::ApbAddrW-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import fmnco_pkg::*;

    t_cfg      r_cfg;
    logic      w_cfg_wr;
    logic      w_enable;
    logic      w_push;
    logic      w_pop;
    t_lut_idx  w_push_idx;
    t_lut_idx  w_pop_idx;
    t_q_status w_q_status;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.carrier <= CarrierReset;
            r_cfg.gain    <= GainReset;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                RegCarrier: r_cfg.carrier <= pwdata;
                RegGain:    r_cfg.gain    <= pwdata;
                default:    r_cfg         <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            RegCarrier: prdata = r_cfg.carrier;
            RegGain:    prdata = r_cfg.gain;
            default:    prdata = '0;
        endcase
    end

    fmnco_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_enable   (w_enable),
        .i_q_status (w_q_status),
        .i_pcm      (i_pcm),
        .o_push     (w_push),
        .o_push_idx (w_push_idx)
    );

    fmnco_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_idx (w_push_idx),
        .i_pop      (w_pop),
        .o_pop_idx  (w_pop_idx),
        .o_status   (w_q_status)
    );

    fmnco_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_pop_idx  (w_pop_idx),
        .o_pop      (w_pop),
        .o_ready    (w_enable),
        .o_fm       (o_fm)
    );
endmodule
